FILE: design/ctcg_pkg.sv
package ctcg_pkg;

    // Fixed field widths of the streams and of the sequence totals.
    localparam int SCORE_W   = 16;
    localparam int SUM_W     = 25;
    localparam int DICT_W    = 14;
    localparam int OUT_IDX_W = 13;
    localparam int OUT_CNT_W = 9;
    // Widest index and count that the parameter ranges allow.
    localparam int EVT_IDX_W = 16;
    localparam int EVT_CNT_W = 13;
    // One quotient bit per divider step.
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    localparam logic signed [SUM_W-1:0] SUM_MAX = 25'sh0FFFFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 25'sh1000000;
    localparam logic [DICT_W-1:0] DICT_RESET = 14'd6625;

    // Result kinds.
    localparam logic KIND_SYM = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      end_of_step;
        logic                      end_of_sequence;
    } t_item;

    typedef struct packed {
        logic                        kind;
        logic [OUT_IDX_W-1:0]        symbol_index;
        logic signed [SCORE_W-1:0]   symbol_score;
        logic                        in_dict;
        logic [OUT_CNT_W-1:0]        symbol_count;
        logic signed [SCORE_W-1:0]   average_score;
        logic                        last;
    } t_res;

    // One entry per step end that causes a result.
    typedef struct packed {
        logic                      sym_vld;
        logic                      eos;
        logic [EVT_IDX_W-1:0]      idx;
        logic signed [SCORE_W-1:0] score;
        logic [EVT_CNT_W-1:0]      cnt;
        logic signed [SUM_W-1:0]   sum;
    } t_evt;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [EVT_CNT_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                      done;
        logic signed [SCORE_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SYM,
        BK_START,
        BK_DIV,
        BK_SUM
    } t_bstate;

endpackage

FILE: design/ctcg_front.sv
module ctcg_front #(
    parameter int MAX_CLASSES = 8192,
    parameter int MAX_STEPS   = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ctcg_pkg::t_item i_in_item,
    input  logic            i_q_full,
    output logic            o_q_push,
    output ctcg_pkg::t_evt  o_q_data
);
    import ctcg_pkg::*;

    localparam int CLW = $clog2(MAX_CLASSES + 1);
    localparam int IW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNW = $clog2(MAX_STEPS + 1);

    logic signed [SCORE_W-1:0] r_best_score, n_best_score;
    logic [IW-1:0]             r_best_idx, n_best_idx;
    logic [CLW-1:0]            r_cls_cnt, n_cls_cnt;
    logic [IW-1:0]             r_prev_idx, n_prev_idx;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [CNW-1:0]            r_emit_cnt, n_emit_cnt;

    logic                      accept;
    logic                      take;
    logic                      upd;
    logic                      eostep;
    logic                      emit;
    logic                      add;
    logic signed [SCORE_W-1:0] cur_score;
    logic [IW-1:0]             cur_idx;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic [CNW-1:0]            cnt_new;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Running maximum of the current step; scores past the class limit do not compete.
    always_comb begin
        take      = r_cls_cnt < CLW'(MAX_CLASSES);
        upd       = take && ((r_cls_cnt == '0) || (i_in_item.score > r_best_score));
        cur_score = upd ? i_in_item.score : r_best_score;
        cur_idx   = upd ? r_cls_cnt[IW-1:0] : r_best_idx;
        eostep    = i_in_item.end_of_step || i_in_item.end_of_sequence;
        emit      = eostep && (cur_idx != '0) && (cur_idx != r_prev_idx);
        add       = emit && (r_emit_cnt < CNW'(MAX_STEPS));
    end

    // Saturating sequence sum and symbol count.
    always_comb begin
        sum_wide = (SUM_W+1)'(r_sum) + (SUM_W+1)'(cur_score);
        if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
            sum_sat = SUM_MAX;
        end else if (sum_wide < (SUM_W+1)'(SUM_MIN)) begin
            sum_sat = SUM_MIN;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        cnt_new = add ? r_emit_cnt + CNW'(1) : r_emit_cnt;
    end

    // Next state of the step and sequence tracking.
    always_comb begin
        n_best_score = r_best_score;
        n_best_idx   = r_best_idx;
        n_cls_cnt    = r_cls_cnt;
        n_prev_idx   = r_prev_idx;
        n_sum        = r_sum;
        n_emit_cnt   = r_emit_cnt;
        if (accept) begin
            n_best_score = cur_score;
            n_best_idx   = cur_idx;
            if (take) begin
                n_cls_cnt = r_cls_cnt + CLW'(1);
            end
            if (add) begin
                n_sum = sum_sat;
            end
            n_emit_cnt = cnt_new;
            if (eostep) begin
                n_prev_idx   = cur_idx;
                n_cls_cnt    = '0;
                n_best_idx   = '0;
                n_best_score = '0;
            end
            if (i_in_item.end_of_sequence) begin
                n_prev_idx = '0;
                n_sum      = '0;
                n_emit_cnt = '0;
            end
        end
    end

    // An item that ends a step with a symbol, or ends the sequence, queues one entry.
    always_comb begin
        o_q_push         = accept && (emit || i_in_item.end_of_sequence);
        o_q_data.sym_vld = emit;
        o_q_data.eos     = i_in_item.end_of_sequence;
        o_q_data.idx     = EVT_IDX_W'(cur_idx);
        o_q_data.score   = cur_score;
        o_q_data.cnt     = EVT_CNT_W'(cnt_new);
        o_q_data.sum     = add ? sum_sat : r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score <= '0;
            r_best_idx   <= '0;
            r_cls_cnt    <= '0;
            r_prev_idx   <= '0;
            r_sum        <= '0;
            r_emit_cnt   <= '0;
        end else begin
            r_best_score <= n_best_score;
            r_best_idx   <= n_best_idx;
            r_cls_cnt    <= n_cls_cnt;
            r_prev_idx   <= n_prev_idx;
            r_sum        <= n_sum;
            r_emit_cnt   <= n_emit_cnt;
        end
    end

    // A sequence end leaves the tracking clear for the next sequence.
    a_seq_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.end_of_sequence) |=>
            (r_cls_cnt == '0 && r_emit_cnt == '0 && r_prev_idx == '0 && r_sum == '0))
        else $error("sequence state not cleared after end of sequence");

    // The symbol count never passes its limit.
    a_cnt_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_cnt <= CNW'(MAX_STEPS))
        else $error("symbol count above limit");

endmodule

FILE: design/ctcg_queue.sv
module ctcg_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ctcg_pkg::t_evt i_data,
    output logic           o_full,
    input  logic           i_pop,
    output ctcg_pkg::t_evt o_data,
    output logic           o_empty
);
    import ctcg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_evt           r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into a full queue");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from an empty queue");

endmodule

FILE: design/ctcg_div.sv
module ctcg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctcg_pkg::t_div_req i_req,
    output ctcg_pkg::t_div_rsp o_rsp
);
    import ctcg_pkg::*;

    logic                    r_busy, n_busy;
    logic                    r_fin, n_fin;
    logic                    r_done, n_done;
    logic [DIV_STEP_W-1:0]   r_step, n_step;
    logic [EVT_CNT_W:0]      r_rem, n_rem;
    logic [SUM_W-1:0]        r_quo, n_quo;
    logic                    r_neg, n_neg;
    logic [EVT_CNT_W-1:0]    r_dvs, n_dvs;
    logic signed [SCORE_W-1:0] r_q, n_q;

    logic [EVT_CNT_W:0]      rem_sh;
    logic                    ge;

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_comb begin
        rem_sh = {r_rem[EVT_CNT_W-1:0], r_quo[SUM_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
    end

    always_comb begin
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_neg  = r_neg;
        n_dvs  = r_dvs;
        n_q    = r_q;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_neg  = i_req.dividend[SUM_W-1];
            n_quo  = i_req.dividend[SUM_W-1] ? SUM_W'(-i_req.dividend) : i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem  = ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
            n_quo  = {r_quo[SUM_W-2:0], ge};
            n_step = r_step + DIV_STEP_W'(1);
            if (r_step == DIV_STEP_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
        // Sign and saturate the finished quotient.
        if (r_fin) begin
            n_done = 1'b1;
            if (!r_neg) begin
                n_q = (r_quo > SUM_W'(32767)) ? 16'sh7FFF : r_quo[SCORE_W-1:0];
            end else begin
                n_q = (r_quo > SUM_W'(32768)) ? 16'sh8000 : SCORE_W'(-r_quo[SCORE_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_neg <= n_neg;
        r_dvs <= n_dvs;
        r_q   <= n_q;
    end

    a_done_after_fin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_fin))
        else $error("divider done without a finished run");

endmodule

FILE: design/ctcg_back.sv
module ctcg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [13:0]        i_cfg_data,
    input  logic               i_q_empty,
    input  ctcg_pkg::t_evt     i_q_data,
    output logic               o_q_pop,
    output ctcg_pkg::t_div_req o_div_req,
    input  ctcg_pkg::t_div_rsp i_div_rsp,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ctcg_pkg::t_res     o_out_item
);
    import ctcg_pkg::*;

    t_bstate                   r_state, n_state;
    t_evt                      r_ent, n_ent;
    logic signed [SCORE_W-1:0] r_avg, n_avg;
    logic                      r_out_vld, n_out_vld;
    t_res                      r_out, n_out;
    logic [DICT_W-1:0]         r_dict;
    logic                      slot_free;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign slot_free   = !r_out_vld || i_out_ready;

    // Dictionary size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dict <= DICT_RESET;
        end else if (i_cfg_we) begin
            r_dict <= i_cfg_data;
        end
    end

    // Result sequencer: symbol if any, then at sequence end the summary.
    always_comb begin
        n_state            = r_state;
        n_ent              = r_ent;
        n_avg              = r_avg;
        n_out_vld          = r_out_vld;
        n_out              = r_out;
        o_q_pop            = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_ent.sum;
        o_div_req.divisor  = r_ent.cnt;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_ent   = i_q_data;
                    n_state = i_q_data.sym_vld ? BK_SYM : BK_START;
                end
            end
            BK_SYM: begin
                if (slot_free) begin
                    n_out_vld          = 1'b1;
                    n_out              = '0;
                    n_out.kind         = KIND_SYM;
                    n_out.symbol_index = OUT_IDX_W'(r_ent.idx);
                    n_out.symbol_score = r_ent.score;
                    n_out.in_dict      = r_ent.idx < EVT_IDX_W'(r_dict);
                    n_out.last         = !r_ent.eos;
                    n_state            = r_ent.eos ? BK_START : BK_IDLE;
                end
            end
            BK_START: begin
                if (r_ent.cnt == '0) begin
                    n_avg   = '0;
                    n_state = BK_SUM;
                end else begin
                    o_div_req.start = 1'b1;
                    n_state         = BK_DIV;
                end
            end
            BK_DIV: begin
                if (i_div_rsp.done) begin
                    n_avg   = i_div_rsp.quo;
                    n_state = BK_SUM;
                end
            end
            BK_SUM: begin
                if (slot_free) begin
                    n_out_vld           = 1'b1;
                    n_out               = '0;
                    n_out.kind          = KIND_SUM;
                    n_out.symbol_count  = OUT_CNT_W'(r_ent.cnt);
                    n_out.average_score = r_avg;
                    n_out.last          = 1'b1;
                    n_state             = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        r_avg <= n_avg;
        r_out <= n_out;
    end

    // A summary is only built for an entry that ends a sequence.
    a_sum_needs_eos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SUM || r_state == BK_DIV || r_state == BK_START) |-> r_ent.eos)
        else $error("summary started for an entry without sequence end");

endmodule

FILE: design/ctc_greedy_decoder.sv
// Greedy CTC decoder over a stream of class scores.
// Input channel (i_in_valid / o_in_ready) takes one signed Q1.14 score per item,
// in class order, with end_of_step on the last class of a time step and
// end_of_sequence on the last step of a sequence. Output channel
// (o_out_valid / i_out_ready) gives a symbol item when a step's winning class is
// not blank and differs from the previous step's winner, and a summary item
// (count and truncated mean score) at each sequence end.
// Throughput: one score item per cycle. A step end that emits a symbol passes
// the queue, the sequencer state and the output register. A summary also waits
// for the divider, which produces one quotient bit a cycle. A four-entry queue
// between the scoring front and the result back lets the next sequence stream in
// during the division; input stalls only when the queue is full, which happens
// when the receiver stalls or sequences are very short. Reset clears all step and
// sequence tracking, empties the queue and output register and sets the dictionary
// size to 6625. While the receiver holds i_out_ready low the output item stays put
// and the queue fills behind it. The user must write the dictionary size through
// i_cfg_we / i_cfg_data only while idle; the block itself does not enforce this.
module ctc_greedy_decoder #(
    parameter int MAX_CLASSES = 8192,
    parameter int MAX_STEPS   = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [13:0]     i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ctcg_pkg::t_item i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ctcg_pkg::t_res  o_out_item
);
    import ctcg_pkg::*;

    localparam int Q_DEPTH = 4;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    t_evt     q_wdata;
    t_evt     q_rdata;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // Scoring front: running argmax, symbol decision and sequence totals.
    ctcg_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    // Queue of step-end entries.
    ctcg_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Mean score divider.
    ctcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Result back end with the output register.
    ctcg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
